// ----- rtl/base64_stream_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Concurrent assertion shorthands used by the encoder top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define B64_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define B64_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the sextet-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

  localparam int unsigned ByteW             = 8;
  localparam int unsigned CharW             = 7;
  localparam int unsigned LeftW             = 4;
  localparam int unsigned NumSlots          = 4;
  localparam int unsigned SlotW             = $clog2(NumSlots);
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CharW-1:0] PadChar = 7'h3D;  // '='

  // Index of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } grp_pos_e;

  // Characters produced by one input byte
  typedef struct packed {
    logic [NumSlots-1:0][CharW-1:0] chars;
    logic [SlotW-1:0]               last_idx;
    logic                           eom;
  } job_t;

  typedef struct packed {
    grp_pos_e         pos;
    logic [LeftW-1:0] left;
  } front_stat_t;

  typedef struct packed {
    logic             busy;
    logic [SlotW-1:0] idx;
  } back_stat_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [CharW-1:0] enc6(input logic [5:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64enc_in_if.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder input channel
// Valid/ready channel carrying one raw byte and its end-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/b64enc_out_if.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder output channel
// Valid/ready channel carrying one ASCII character and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_message;

  modport source (output valid, output out_char, output end_of_message, input ready);
  modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

`default_nettype wire

// ----- rtl/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream in, RFC 4648 base64 characters with '=' padding out.
//
//   Channel  Dir  Payload                         Request
//   in_i     in   data_byte[7:0], last_byte       one raw message byte
//   out_o    out  out_char[6:0], end_of_message   one ASCII character
//
// An accepted byte reaches the queue in the same cycle; its first character
// then passes through the back end's group register and output register to out_o.
// The output side moves one character per cycle while out_o is ready, which
// sets throughput.
// The queue absorbs bursts of up to QueueDepth bytes ahead of the output.
// Reset clears the group position, queue and output register; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_encoder_macros.svh"

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64enc_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64enc_in_if.sink     in_i,
  b64enc_out_if.source  out_o
);
  import b64enc_pkg::*;

  localparam int unsigned LevelW = $clog2(QueueDepth + 1);

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  job_t              push_job, pop_job;
  logic [LevelW-1:0] queue_level;
  front_stat_t       front_stat;
  back_stat_t        back_stat;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job),
    .stat_o       (front_stat)
  );

  b64enc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job),
    .level_o      (queue_level)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o),
    .stat_o      (back_stat)
  );

  `B64_ASSERT_NEXT(a_last_byte_closes_group, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.last_byte, front_stat.pos == POS_FIRST && front_stat.left == '0, "group not closed after last byte")
  `B64_ASSERT_IMPL(a_queue_level_bound, clk_i, rst_ni, 1'b1, queue_level <= LevelW'(QueueDepth), "queue level exceeds depth")
  `B64_ASSERT_NEXT(a_back_loads_group, clk_i, rst_ni, queue_level != '0 && !back_stat.busy, back_stat.busy, "back end idle with queued group")

endmodule

`default_nettype wire

// ----- rtl/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group position and builds each byte's characters.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  b64enc_in_if.sink                in_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output b64enc_pkg::job_t         push_job_o,
  output b64enc_pkg::front_stat_t  stat_o
);
  import b64enc_pkg::*;

  grp_pos_e         pos_q, pos_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [ByteW-1:0] b;
  logic             take;
  job_t             job;

  assign b            = in_i.data_byte;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign take         = in_i.valid && push_ready_i;
  assign push_job_o   = job;
  assign stat_o       = '{pos: pos_q, left: left_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_FIRST;
      left_q <= '0;
    end else if (take) begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

  // Next group state and the characters this byte completes
  always_comb begin
    pos_d        = POS_FIRST;
    left_d       = '0;
    job.chars    = {NumSlots{PadChar}};
    job.last_idx = SlotW'(0);
    job.eom      = 1'b0;
    unique case (pos_q)
      POS_SECOND: begin
        // only two leftover bits are held after the first byte
        job.chars[0] = enc6({left_q[1:0], b[7:4]});
        if (in_i.last_byte) begin
          job.chars[1] = enc6({b[3:0], 2'b00});
          job.last_idx = SlotW'(2);
          job.eom      = 1'b1;
        end else begin
          left_d = b[3:0];
          pos_d  = POS_THIRD;
        end
      end
      POS_THIRD: begin
        job.chars[0] = enc6({left_q, b[7:6]});
        job.chars[1] = enc6(b[5:0]);
        job.last_idx = SlotW'(1);
        job.eom      = in_i.last_byte;
      end
      default: begin
        // first byte of a group; the unused code behaves the same
        job.chars[0] = enc6(b[7:2]);
        if (in_i.last_byte) begin
          job.chars[1] = enc6({b[1:0], 4'b0000});
          job.last_idx = SlotW'(3);
          job.eom      = 1'b1;
        end else begin
          left_d = {2'b00, b[1:0]};
          pos_d  = POS_SECOND;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/b64enc_fifo.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder request queue
// Small FIFO of character groups between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_fifo #(
  parameter int unsigned Depth = b64enc_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_valid_i,
  output logic                             push_ready_o,
  input  b64enc_pkg::job_t                 push_job_i,
  output logic                             pop_valid_o,
  input  logic                             pop_ready_i,
  output b64enc_pkg::job_t                 pop_job_o,
  output logic [$clog2(Depth+1)-1:0]       level_o
);
  import b64enc_pkg::*;

  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned LevelW = $clog2(Depth + 1);

  job_t              mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              push, pop;

  assign push_ready_o = (level_q != LevelW'(Depth));
  assign pop_valid_o  = (level_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign level_o      = level_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      level_d = level_q + LevelW'(1);
    end else if (pop && !push) begin
      level_d = level_q - LevelW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks each character group and drives one character per cycle out while out_o is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  b64enc_pkg::job_t        pop_job_i,
  b64enc_out_if.source            out_o,
  output b64enc_pkg::back_stat_t  stat_o
);
  import b64enc_pkg::*;

  job_t             job_q;
  logic             busy_q, busy_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;
  logic             out_eom_q;
  logic             emit, at_last, pop;

  assign emit    = busy_q && (!out_valid_q || out_o.ready);
  assign at_last = (idx_q == job_q.last_idx);
  assign pop_ready_o = !busy_q || (emit && at_last);
  assign pop     = pop_valid_i && pop_ready_o;

  assign out_o.valid          = out_valid_q;
  assign out_o.out_char       = out_char_q;
  assign out_o.end_of_message = out_eom_q;
  assign stat_o = '{busy: busy_q, idx: idx_q};

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (emit) begin
      idx_d = idx_q + SlotW'(1);
    end
    // retire the group on its final character, then load the next one
    if (emit && at_last) begin
      busy_d = 1'b0;
    end
    if (pop) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q <= pop_job_i;
    end
    if (emit) begin
      out_char_q <= job_q.chars[idx_q];
      out_eom_q  <= at_last && job_q.eom;
    end
  end

endmodule

`default_nettype wire
